### rtl/core/wtss_pkg.sv
// Package for the weighted tardiness swap search block.
// Holds the job record type and penalty constants; no dependencies.
`timescale 1ns / 1ps
package wtss_pkg;
    localparam int PEN_W = 26;
    localparam logic [PEN_W-1:0] PEN_MAX = {PEN_W{1'b1}};

    typedef struct packed {
        logic [7:0]  proc;
        logic [7:0]  weight;
        logic [15:0] due;
        logic [6:0]  number;
    } t_job;
endpackage

### rtl/core/weighted_tardiness_swap_search.sv
// Weighted tardiness swap search: top level with job memory and sequencer.
// Depends on wtss_pkg for the job record and penalty constants.
`timescale 1ns / 1ps
// Usage:
// Jobs arrive on the input channel (i_proc_time, i_job_weight, i_due_date,
// i_last_job), one transaction per job, and are numbered from 1. Jobs beyond
// MAX_JOBS are dropped. A job with i_last_job set starts the search: the
// stored jobs are insertion sorted by due date (stable), then every swap
// trial (i, j, k) is evaluated and kept if the total weighted tardiness
// strictly drops. Afterwards one output transaction per job gives the
// arrival number in schedule order, the final penalty, and o_last_of_order
// on the final one. A penalty walk reads the job memory once. Each (i, j, k)
// step passes through the select state, a real trial adds a walk and a kept
// swap the swap states that read both jobs and write them back exchanged; the
// job memory has a single read port. Each result is read, latched and then
// held until the receiver takes it. Input is not accepted from the last job
// until the last result is taken. A stalled receiver holds the current result.
// Reset clears the job count, the penalty and max_swap_offset; the job memory
// is not cleared. The config channel writes max_swap_offset and is always
// ready; it is to be written only while idle, which the block itself does not
// enforce.
module weighted_tardiness_swap_search #(
    parameter int MAX_JOBS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_proc_time,
    input  logic [7:0]  i_job_weight,
    input  logic [15:0] i_due_date,
    input  logic        i_last_job,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_job_number,
    output logic [25:0] o_total_penalty,
    output logic        o_last_of_order,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);
    localparam int AW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);

    typedef enum logic [13:0] {
        S_LOAD = 14'b00000000000001,
        S_SRD  = 14'b00000000000010, // sort: read key at i
        S_SKEY = 14'b00000000000100, // sort: latch key, read j-1
        S_SCMP = 14'b00000000001000, // sort: compare, shift or place
        S_SPUT = 14'b00000000010000, // sort: place key at 0
        S_PEN  = 14'b00000000100000, // penalty walk
        S_TSEL = 14'b00000001000000, // pick next swap trial
        S_SWA  = 14'b00000010000000, // swap: read a
        S_SWB  = 14'b00000100000000, // swap: latch a, read b
        S_SWC  = 14'b00001000000000, // swap: write b at a
        S_SWD  = 14'b00010000000000, // swap: write a at b
        S_ORD  = 14'b00100000000000, // emit: read
        S_OLD  = 14'b01000000000000, // emit: latch result
        S_OUT  = 14'b10000000000000  // emit: wait for receiver
    } t_state;

    t_state r_state;
    wtss_pkg::t_job mem [MAX_JOBS];
    wtss_pkg::t_job r_rd;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wr_addr;
    wtss_pkg::t_job wr_data;

    logic [CW-1:0] r_cnt;
    logic [4:0]    r_kmax;
    logic [25:0]   r_pen, r_cur, r_best;
    logic [CW-1:0] r_i, r_j, r_p;
    logic [4:0]    r_k;
    logic [AW-1:0] r_other;
    wtss_pkg::t_job r_key;
    logic [16:0]   r_time;
    logic [16:0]   r_late;
    logic [7:0]    r_wt;
    logic          r_v1, r_v2;
    logic          r_phase;  // 0: walk of the sorted order, 1: trial walk
    logic          r_ovalid;
    logic          r_olast;
    logic [5:0]    r_onum;

    logic [16:0]   sum_time;
    logic [16:0]   late;
    logic [24:0]   term;
    logic [26:0]   psum;
    logic [25:0]   pen_sat;
    logic [AW-1:0] pa, walk_addr, trial_other;
    logic          trial_ok, shift_ok;
    logic [CW-1:0] step_i, step_j;
    logic [4:0]    step_k;
    logic          in_acc, out_acc, cfg_acc;

    // job memory with registered read
    always_ff @(posedge i_clk) begin
        if (we) mem[wr_addr] <= wr_data;
        r_rd <= mem[rd_addr];
    end

    // penalty pipeline: completion and lateness, then weighted sum
    assign sum_time = r_time + {9'd0, r_rd.proc};
    assign late     = (sum_time > {1'b0, r_rd.due}) ? sum_time - {1'b0, r_rd.due} : 17'd0;
    assign term     = {8'd0, r_late} * {17'd0, r_wt};
    assign psum     = {1'b0, r_pen} + {2'b0, term};
    assign pen_sat  = psum[26] ? wtss_pkg::PEN_MAX : psum[25:0];

    // walk order with positions i and other exchanged
    assign pa          = r_p[AW-1:0];
    assign walk_addr   = (pa == r_i[AW-1:0]) ? r_other :
                         (pa == r_other)     ? r_i[AW-1:0] : pa;
    assign trial_other = AW'(32'(r_j) - 32'(r_k));
    assign trial_ok    = (32'(r_j) >= 32'(r_k)) && (trial_other != r_i[AW-1:0]);
    assign shift_ok    = r_rd.due > r_key.due;

    assign o_ready         = (r_state == S_LOAD);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_ovalid;
    assign o_job_number    = r_onum;
    assign o_total_penalty = r_best;
    assign o_last_of_order = r_olast;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = r_ovalid && i_ready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;

    // advance the (i, j, k) trial counters
    always_comb begin
        step_i = r_i;
        step_j = r_j;
        step_k = r_k + 5'd1;
        if (r_k == r_kmax) begin
            step_k = '0;
            if (r_j == r_cnt - 1'b1) begin
                step_j = CW'(1);
                step_i = r_i + 1'b1;
            end else begin
                step_j = r_j + 1'b1;
            end
        end
    end

    // memory addresses and write data per state
    always_comb begin
        we      = 1'b0;
        wr_addr = r_cnt[AW-1:0];
        wr_data = r_key;
        rd_addr = r_p[AW-1:0];
        unique case (r_state)
            S_LOAD: begin
                we      = in_acc && (r_cnt < CW'(MAX_JOBS));
                wr_data = '{proc: i_proc_time, weight: i_job_weight, due: i_due_date,
                            number: 7'(r_cnt + 1'b1)};
            end
            S_SRD:  rd_addr = r_i[AW-1:0];
            S_SKEY: rd_addr = AW'(r_j - 1'b1);
            S_SCMP: begin
                // shift the larger entry up or drop the key in place
                we      = 1'b1;
                wr_addr = r_j[AW-1:0];
                wr_data = shift_ok ? r_rd : r_key;
                rd_addr = AW'(r_j - 2'd2);
            end
            S_SPUT: begin
                we      = 1'b1;
                wr_addr = '0;
                wr_data = r_key;
            end
            S_PEN:  rd_addr = walk_addr;
            S_SWA:  rd_addr = r_i[AW-1:0];
            S_SWB:  rd_addr = r_other;
            S_SWC: begin
                we      = 1'b1;
                wr_addr = r_i[AW-1:0];
                wr_data = r_rd;
            end
            S_SWD: begin
                we      = 1'b1;
                wr_addr = r_other;
                wr_data = r_key;
            end
            S_TSEL, S_ORD, S_OLD, S_OUT: ;
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_kmax   <= '0;
            r_best   <= '0;
            r_ovalid <= 1'b0;
            r_olast  <= 1'b0;
            r_onum   <= '0;
        end else begin
            if (cfg_acc) r_kmax <= i_cfg_data;
            unique case (r_state)
                // store the job, drop it when full
                S_LOAD: if (in_acc) begin
                    if (r_cnt < CW'(MAX_JOBS)) r_cnt <= r_cnt + 1'b1;
                    if (i_last_job) begin
                        r_i     <= CW'(1);
                        r_state <= S_SRD;
                    end
                end
                // insertion sort, one shift per cycle
                S_SRD: begin
                    if (r_i >= r_cnt) begin
                        r_i     <= '0;
                        r_other <= '0;
                        r_phase <= 1'b0;
                        r_p     <= '0;
                        r_v1    <= 1'b0;
                        r_v2    <= 1'b0;
                        r_time  <= '0;
                        r_pen   <= '0;
                        r_state <= S_PEN;
                    end else begin
                        r_j     <= r_i;
                        r_state <= S_SKEY;
                    end
                end
                S_SKEY: begin
                    r_key   <= r_rd;
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    if (shift_ok) begin
                        r_j <= r_j - 1'b1;
                        if (r_j == CW'(1)) r_state <= S_SPUT;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_SPUT: begin
                    r_i     <= r_i + 1'b1;
                    r_state <= S_SRD;
                end
                // penalty walk over the schedule
                S_PEN: begin
                    r_v1 <= (r_p < r_cnt);
                    if (r_p < r_cnt) r_p <= r_p + 1'b1;
                    r_v2 <= r_v1;
                    if (r_v1) begin
                        r_time <= sum_time;
                        r_late <= late;
                        r_wt   <= r_rd.weight;
                    end
                    if (r_v2) r_pen <= pen_sat;
                    if (r_p == r_cnt && !r_v1 && !r_v2) begin
                        if (!r_phase) begin
                            r_cur <= r_pen;
                            if (r_cnt < CW'(2)) begin
                                r_best  <= r_pen;
                                r_p     <= '0;
                                r_state <= S_ORD;
                            end else begin
                                r_i     <= '0;
                                r_j     <= CW'(1);
                                r_k     <= '0;
                                r_state <= S_TSEL;
                            end
                        end else if (r_cur > r_pen) begin
                            // strict improvement: commit the swap
                            r_cur   <= r_pen;
                            r_state <= S_SWA;
                        end else begin
                            r_i     <= step_i;
                            r_j     <= step_j;
                            r_k     <= step_k;
                            r_state <= S_TSEL;
                        end
                    end
                end
                // start the next real trial or finish the search
                S_TSEL: begin
                    if (r_i >= r_cnt) begin
                        r_best  <= r_cur;
                        r_p     <= '0;
                        r_state <= S_ORD;
                    end else if (trial_ok) begin
                        r_other <= trial_other;
                        r_phase <= 1'b1;
                        r_p     <= '0;
                        r_v1    <= 1'b0;
                        r_v2    <= 1'b0;
                        r_time  <= '0;
                        r_pen   <= '0;
                        r_state <= S_PEN;
                    end else begin
                        r_i <= step_i;
                        r_j <= step_j;
                        r_k <= step_k;
                    end
                end
                S_SWA: r_state <= S_SWB;
                S_SWB: begin
                    r_key   <= r_rd;
                    r_state <= S_SWC;
                end
                S_SWC: r_state <= S_SWD;
                S_SWD: begin
                    r_i     <= step_i;
                    r_j     <= step_j;
                    r_k     <= step_k;
                    r_state <= S_TSEL;
                end
                // emit the order, one transaction per job
                S_ORD: r_state <= S_OLD;
                S_OLD: begin
                    r_onum   <= r_rd.number[5:0];
                    r_olast  <= (r_p == r_cnt - 1'b1);
                    r_ovalid <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: if (out_acc) begin
                    r_ovalid <= 1'b0;
                    if (r_olast) begin
                        r_cnt   <= '0;
                        r_state <= S_LOAD;
                    end else begin
                        r_p     <= r_p + 1'b1;
                        r_state <= S_ORD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // hold the result while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_job_number)
            && $stable(o_total_penalty) && $stable(o_last_of_order));

    // never take input while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready));

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state));

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_JOBS));
endmodule

### tb/tb_top.sv
// Self-checking testbench for weighted_tardiness_swap_search.
// Needs wtss_pkg and the top level; predicts every schedule and checks each result.
`timescale 1ns / 1ps
module tb_top;
    localparam int NJOBS      = 32;
    localparam int WDOG_LIMIT = 300000;
    localparam int LONG_HOLD  = 4000;

    typedef struct packed {
        logic [7:0]  proc;
        logic [7:0]  weight;
        logic [15:0] due;
        logic        last;
    } t_job_item;

    typedef struct packed {
        logic [5:0]                 number;
        logic [wtss_pkg::PEN_W-1:0] penalty;
        logic                       last;
    } t_sched_slot;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [7:0]  i_proc_time = 0;
    logic [7:0]  i_job_weight = 0;
    logic [15:0] i_due_date = 0;
    logic        i_last_job = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [5:0]  o_job_number;
    logic [25:0] o_total_penalty;
    logic        o_last_of_order;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data = 0;

    weighted_tardiness_swap_search #(.MAX_JOBS(NJOBS)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_proc_time(i_proc_time), .i_job_weight(i_job_weight),
        .i_due_date(i_due_date), .i_last_job(i_last_job),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_job_number(o_job_number), .o_total_penalty(o_total_penalty),
        .o_last_of_order(o_last_of_order),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    t_job_item   pending_jobs[$];
    t_sched_slot expected_order[$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_req = 0;
    bit          in_taken = 0;
    int          errors = 0;
    int          jobs_taken = 0;
    int          slots_checked = 0;
    int          sets_scheduled = 0;

    // schedule predictor state
    logic [7:0]  sp_proc[NJOBS];
    logic [7:0]  sp_weight[NJOBS];
    logic [15:0] sp_due[NJOBS];
    logic [6:0]  sp_num[NJOBS];
    int          sp_count = 0;
    logic [4:0]  sp_kmax = 0;

    function automatic logic [wtss_pkg::PEN_W-1:0] tardiness_sum(int n);
        longint t, sum;
        t = 0;
        sum = 0;
        for (int i = 0; i < n; i++) begin
            t += sp_proc[i];
            if (sp_due[i] < t) begin
                sum += sp_weight[i] * (t - sp_due[i]);
                if (sum > wtss_pkg::PEN_MAX) sum = wtss_pkg::PEN_MAX;
            end
        end
        return sum[wtss_pkg::PEN_W-1:0];
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [7:0]  p, w;
        logic [15:0] d;
        logic [6:0]  nb;
        p = sp_proc[a]; w = sp_weight[a]; d = sp_due[a]; nb = sp_num[a];
        sp_proc[a] = sp_proc[b]; sp_weight[a] = sp_weight[b];
        sp_due[a] = sp_due[b]; sp_num[a] = sp_num[b];
        sp_proc[b] = p; sp_weight[b] = w; sp_due[b] = d; sp_num[b] = nb;
    endfunction

    // Store one job; on the last one sort, search and queue the schedule.
    function automatic void predict_schedule(t_job_item jb);
        int n, j;
        logic [wtss_pkg::PEN_W-1:0] prev, pen;
        t_sched_slot slot;
        if (sp_count < NJOBS) begin
            sp_proc[sp_count] = jb.proc;
            sp_weight[sp_count] = jb.weight;
            sp_due[sp_count] = jb.due;
            sp_num[sp_count] = 7'(sp_count + 1);
            sp_count++;
        end
        if (!jb.last) return;
        n = sp_count;
        // stable insertion sort by due date
        for (int i = 1; i < n; i++) begin
            j = i;
            while (j > 0 && sp_due[j-1] > sp_due[j]) begin
                swap_slots(j - 1, j);
                j--;
            end
        end
        // pairwise swap search, keep only strict improvements
        for (int i = 0; i < n; i++)
            for (int jj = 1; jj < n; jj++)
                for (int k = 0; k <= sp_kmax; k++)
                    if (jj >= k) begin
                        prev = tardiness_sum(n);
                        swap_slots(i, jj - k);
                        if (!(prev > tardiness_sum(n))) swap_slots(i, jj - k);
                    end
        pen = tardiness_sum(n);
        for (int i = 0; i < n; i++) begin
            slot.number  = sp_num[i][5:0];
            slot.penalty = pen;
            slot.last    = (i == n - 1);
            expected_order.insert(expected_order.size(), slot);
        end
        sp_count = 0;
        sets_scheduled++;
    endfunction

    // Sample both channels at the rising edge: predict inputs, check outputs.
    always @(posedge i_clk) begin
        t_sched_slot exp_slot;
        in_taken <= i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            jobs_taken++;
            predict_schedule('{i_proc_time, i_job_weight, i_due_date, i_last_job});
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_order.size() == 0) begin
                $display("%0t: unexpected result num=%0d pen=%0d last=%0d", $time,
                         o_job_number, o_total_penalty, o_last_of_order);
                errors++;
            end else begin
                exp_slot = expected_order.pop_front();
                slots_checked++;
                if (o_job_number !== exp_slot.number) begin
                    $display("%0t: job_number exp %0d got %0d", $time,
                             exp_slot.number, o_job_number);
                    errors++;
                end
                if (o_total_penalty !== exp_slot.penalty) begin
                    $display("%0t: total_penalty exp %0d got %0d", $time,
                             exp_slot.penalty, o_total_penalty);
                    errors++;
                end
                if (o_last_of_order !== exp_slot.last) begin
                    $display("%0t: last_of_order exp %0d got %0d", $time,
                             exp_slot.last, o_last_of_order);
                    errors++;
                end
            end
        end
    end

    // Present the next job at the falling edge, idling at random.
    always @(negedge i_clk) begin
        t_job_item jb;
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (pending_jobs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                jb = pending_jobs.pop_front();
                i_proc_time  <= jb.proc;
                i_job_weight <= jb.weight;
                i_due_date   <= jb.due;
                i_last_job   <= jb.last;
                i_valid      <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Drive ready with random stalls and one long hold-off once a result waits.
    always @(negedge i_clk) begin
        static int  hold_left = 0;
        static bit  hold_used = 0;
        if (hold_req && !hold_used && o_valid) begin
            hold_left = LONG_HOLD;
            hold_used = 1;
        end
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        static int quiet = 0;
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WDOG_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic add_job(int p, int w, int d, bit l);
        t_job_item jb;
        jb.proc   = p[7:0];
        jb.weight = w[7:0];
        jb.due    = d[15:0];
        jb.last   = l;
        pending_jobs.insert(pending_jobs.size(), jb);
    endtask

    // Queue one set of n random jobs; tight due dates make tardiness likely.
    task automatic add_random_set(int n);
        for (int i = 0; i < n; i++)
            add_job($urandom_range(255), $urandom_range(255),
                    ($urandom_range(3) == 0) ? $urandom_range(65535)
                                              : $urandom_range(n * 160),
                    i == n - 1);
    endtask

    task automatic write_offset(logic [4:0] k);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = k;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sp_kmax = k;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain;
        while (pending_jobs.size() > 0 || i_valid || expected_order.size() > 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Queue random sets of up to max_n jobs until about count jobs are queued.
    task automatic random_phase(int count, int max_n);
        int queued;
        int n;
        queued = 0;
        while (queued < count) begin
            n = $urandom_range(max_n, 1);
            add_random_set(n);
            queued += n;
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, single job, equal due dates, full store, no idling
        write_offset(5'd0);
        add_job(0, 0, 0, 1);
        add_job(255, 255, 0, 0);
        add_job(255, 255, 0, 0);
        add_job(0, 255, 65535, 1);
        add_job(100, 1, 50, 0);
        add_job(50, 9, 50, 0);
        add_job(20, 200, 50, 1);
        add_job(200, 3, 10, 0);
        add_job(10, 250, 400, 0);
        add_job(90, 128, 65535, 0);
        add_job(170, 85, 0, 1);
        drain();
        // full store with extra jobs dropped, last flag on a dropped job
        for (int i = 0; i < NJOBS + 2; i++)
            add_job(255, 255, $urandom_range(65535), i == NJOBS + 1);
        for (int i = 0; i < NJOBS; i++)
            add_job($urandom_range(255), $urandom_range(255), $urandom_range(4000),
                    i == NJOBS - 1);
        drain();

        // largest offset with tiny sets, sender idling
        write_offset(5'd31);
        send_idle_pct = 73;
        random_phase(60, 4);
        drain();

        // receiver stalling, with one long hold while further jobs wait
        write_offset(5'($urandom_range(6, 1)));
        send_idle_pct = 0;
        recv_stall_pct = 73;
        hold_req = 1;
        random_phase(50, 8);
        drain();
        write_offset(5'($urandom_range(30, 7)));
        random_phase(20, 3);
        drain();

        // both sides idling
        write_offset(5'd3);
        send_idle_pct = 36;
        recv_stall_pct = 36;
        random_phase(70, 10);
        drain();

        $display("covered %0d jobs in %0d sets, %0d schedule slots checked",
                 jobs_taken, sets_scheduled, slots_checked);
        $display("offsets 0, 3, 31 and random values, all idle and stall modes");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
